FILE: src/nsd_pkg.sv
// Package with the shared types and constants of the netstring deframer.
`timescale 1ns / 1ps
package nsd_pkg;

	localparam int unsigned LengthBits = 16;
	localparam int unsigned MaxLenBits = 16;
	localparam logic [15:0] MaxLenReset = 16'd1024;

	localparam int unsigned QueueDepth = 4;
	localparam int unsigned QueuePtrBits = $clog2(QueueDepth);

	localparam logic [7:0] CharZero = 8'd48;
	localparam logic [7:0] CharNine = 8'd57;
	localparam logic [7:0] CharColon = 8'd58;
	localparam logic [7:0] CharComma = 8'd44;

	localparam logic [2:0] KindData = 3'd0;
	localparam logic [2:0] KindAccept = 3'd1;
	localparam logic [2:0] KindBadTerm = 3'd2;
	localparam logic [2:0] KindBadLen = 3'd3;
	localparam logic [2:0] KindBadSep = 3'd4;

	typedef struct packed {
		logic [7:0] data;
		logic       digit;
		logic       colon;
		logic       comma;
		logic [3:0] value;
	} nsd_item_t;

endpackage

FILE: src/nsd_rx_if.sv
// Input stream interface carrying one received byte per transaction.
`timescale 1ns / 1ps
interface nsd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source(output valid, output in_byte, input ready);
	modport sink(input valid, input in_byte, output ready);
endinterface

FILE: src/nsd_tx_if.sv
// Output stream interface carrying one payload byte or status per transaction.
`timescale 1ns / 1ps
interface nsd_tx_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [7:0]  out_byte;
	logic [15:0] msg_length;
	logic        last;

	modport source(output valid, output kind, output out_byte, output msg_length,
		output last, input ready);
	modport sink(input valid, input kind, input out_byte, input msg_length,
		input last, output ready);
endinterface

FILE: src/netstring_deframer_top.sv
// Netstring deframer: bytes in on rx, payload bytes and frame status out on tx.
// Usage:
// Each rx transaction carries one byte of a stream framed as decimal length,
// ':', payload and ','. Each tx transaction carries one result: a payload
// byte (kind 0) or a status (accepted, bad terminator, bad length or bad
// separator) with the declared length and last set. Skipped bytes, length
// digits and the ':' that opens a payload produce no tx transaction.
// The user must write the largest accepted length through cfg_wr_en and
// cfg_wr_data while idle; the block does not check this. It resets to 1024.
// An accepted byte passes through the byte queue and then the output register
// before its result reaches tx. Throughput is one byte per cycle while tx is
// not stalled, set by the update of the parser state machine in the back end.
// Reset empties the four-entry byte queue, clears tx.valid and puts the
// parser in its idle state.
// When the receiver stalls, the output register holds its result, the
// queue fills and rx.ready drops once the queue is full.
`timescale 1ns / 1ps
module netstring_deframer_top #(
	parameter int unsigned LENGTH_BITS = nsd_pkg::LengthBits
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	nsd_rx_if.sink      rx,
	nsd_tx_if.source    tx
);

	logic               q_full;
	logic               push;
	nsd_pkg::nsd_item_t push_item;
	logic               pop;
	logic               head_valid;
	nsd_pkg::nsd_item_t head_item;

	nsd_front u_front (
		.rx     (rx),
		.q_full (q_full),
		.push   (push),
		.item   (push_item)
	);

	nsd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	nsd_back #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.head_valid  (head_valid),
		.head_item   (head_item),
		.pop         (pop),
		.tx          (tx)
	);

endmodule

FILE: src/nsd_front.sv
// Front end that accepts input bytes and classifies them for the queue.
`timescale 1ns / 1ps
module nsd_front (
	nsd_rx_if.sink            rx,
	input  logic              q_full,
	output logic              push,
	output nsd_pkg::nsd_item_t item
);

	logic [7:0] b;

	assign b        = rx.in_byte;
	assign rx.ready = !q_full;
	assign push     = rx.valid && !q_full;

	always_comb begin
		item.data  = b;
		item.digit = (b >= nsd_pkg::CharZero) && (b <= nsd_pkg::CharNine);
		item.colon = (b == nsd_pkg::CharColon);
		item.comma = (b == nsd_pkg::CharComma);
		item.value = 4'(b - nsd_pkg::CharZero);
	end

endmodule

FILE: src/nsd_queue.sv
// Short queue of classified bytes between the front end and the parser.
`timescale 1ns / 1ps
module nsd_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  nsd_pkg::nsd_item_t push_item,
	output logic               full,
	input  logic               pop,
	output logic               head_valid,
	output nsd_pkg::nsd_item_t head_item
);

	localparam int unsigned Depth = nsd_pkg::QueueDepth;
	localparam int unsigned PtrBits = nsd_pkg::QueuePtrBits;

	nsd_pkg::nsd_item_t mem [Depth];
	logic [PtrBits-1:0] wr_ptr_q;
	logic [PtrBits-1:0] rd_ptr_q;
	logic [PtrBits:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign full       = (count_q == (PtrBits+1)'(Depth));
	assign head_valid = (count_q != '0);
	assign head_item  = mem[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: src/nsd_back.sv
// Parser state machine that turns classified bytes into results.
`timescale 1ns / 1ps
module nsd_back #(
	parameter int unsigned LENGTH_BITS = nsd_pkg::LengthBits
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [15:0]        cfg_wr_data,
	input  logic               head_valid,
	input  nsd_pkg::nsd_item_t head_item,
	output logic               pop,
	nsd_tx_if.source           tx
);

	localparam int unsigned AW = LENGTH_BITS + 1;
	localparam int unsigned MW = AW + 4;
	localparam int unsigned CW = (AW > 16) ? AW : 16;

	localparam logic [1:0] PhIdle = 2'd0;
	localparam logic [1:0] PhSize = 2'd1;
	localparam logic [1:0] PhData = 2'd2;
	localparam logic [1:0] PhTerm = 2'd3;

	localparam logic [AW-1:0] Cap = {1'b1, {LENGTH_BITS{1'b0}}};

	logic [15:0]   max_len_q;
	logic [1:0]    phase_q, phase_d;
	logic [AW-1:0] acc_q, acc_d;
	logic [15:0]   remaining_q, remaining_d;
	logic [15:0]   declared_q, declared_d;

	logic          tx_valid_q;
	logic [2:0]    kind_q;
	logic [7:0]    byte_q;
	logic [15:0]   len_q;
	logic          last_q;

	logic          emit;
	logic [2:0]    kind_d;
	logic [7:0]    byte_d;
	logic [15:0]   len_d;
	logic          last_d;

	logic [MW-1:0] mul;
	logic [CW-1:0] acc_ext;
	logic [15:0]   acc_clamp;
	logic          len_ok;

	assign pop = head_valid && (!tx_valid_q || tx.ready);

	assign mul       = MW'({acc_q, 3'b000}) + MW'({acc_q, 1'b0}) + MW'(head_item.value);
	assign acc_ext   = CW'(acc_q);
	assign acc_clamp = (acc_ext > CW'(16'hFFFF)) ? 16'hFFFF : acc_ext[15:0];
	assign len_ok    = (acc_ext != '0) && (acc_ext <= CW'(max_len_q));

	always_comb begin
		phase_d     = phase_q;
		acc_d       = acc_q;
		remaining_d = remaining_q;
		declared_d  = declared_q;
		emit        = 1'b0;
		kind_d      = nsd_pkg::KindData;
		byte_d      = '0;
		len_d       = '0;
		last_d      = 1'b0;
		case (phase_q)
			PhIdle: begin
				if (head_item.digit) begin
					acc_d   = AW'(head_item.value);
					phase_d = PhSize;
				end
			end
			PhSize: begin
				if (head_item.digit) begin
					acc_d = (mul > MW'(Cap)) ? Cap : mul[AW-1:0];
				end else begin
					acc_d   = '0;
					phase_d = PhIdle;
					if (head_item.colon && len_ok) begin
						declared_d  = acc_ext[15:0];
						remaining_d = acc_ext[15:0];
						phase_d     = PhData;
					end else begin
						emit   = 1'b1;
						kind_d = head_item.colon ? nsd_pkg::KindBadLen : nsd_pkg::KindBadSep;
						len_d  = acc_clamp;
						last_d = 1'b1;
					end
				end
			end
			PhData: begin
				remaining_d = remaining_q - 1'b1;
				if (remaining_q == 16'd1) begin
					phase_d = PhTerm;
				end
				emit   = 1'b1;
				kind_d = nsd_pkg::KindData;
				byte_d = head_item.data;
			end
			PhTerm: begin
				phase_d = PhIdle;
				emit    = 1'b1;
				kind_d  = head_item.comma ? nsd_pkg::KindAccept : nsd_pkg::KindBadTerm;
				len_d   = declared_q;
				last_d  = 1'b1;
			end
			default: begin
				phase_d = PhIdle;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q   <= nsd_pkg::MaxLenReset;
			phase_q     <= PhIdle;
			acc_q       <= '0;
			remaining_q <= '0;
			declared_q  <= '0;
			tx_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				max_len_q <= cfg_wr_data;
			end
			if (pop) begin
				phase_q     <= phase_d;
				acc_q       <= acc_d;
				remaining_q <= remaining_d;
				declared_q  <= declared_d;
				tx_valid_q  <= emit;
			end else if (tx.ready) begin
				tx_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			kind_q <= kind_d;
			byte_q <= byte_d;
			len_q  <= len_d;
			last_q <= last_d;
		end
	end

	assign tx.valid      = tx_valid_q;
	assign tx.kind       = kind_q;
	assign tx.out_byte   = byte_q;
	assign tx.msg_length = len_q;
	assign tx.last       = last_q;

endmodule
